// File: src/kl_divergence_accumulator_defines.svh
// Assertion macros for the divergence accumulator.
// Included by the top level; no other dependencies.
`ifndef KL_DIVERGENCE_ACCUMULATOR_DEFINES_SVH
`define KL_DIVERGENCE_ACCUMULATOR_DEFINES_SVH
// Assert that an implication holds at each clock edge outside reset.
`define KLD_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Assert that a condition holds in the cycle after a trigger.
`define KLD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: src/kld_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the divergence accumulator.
// No dependencies.
package kld_pkg;

  localparam int unsigned MaxItems = 65536;
  localparam int CountW = $clog2(MaxItems + 1);
  localparam logic [32:0] OneQ31 = 33'h0_8000_0000;
  localparam logic [47:0] KeptMax = 48'hFFFF_FFFF_FFFF;
  localparam logic [40:0] QuotLimit = 41'h100_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOGP,
    ST_LOGQ,
    ST_MUL,
    ST_ACC,
    ST_FINAL,
    ST_DIV,
    ST_LOGS,
    ST_OUT,
    ST_HOLD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic log_start;  // start log2 unit
    logic log_sel_q;  // operand: 0 p, 1 q
    logic log_sel_s;  // operand: kept sum
    logic save_lp;
    logic save_lq;
    logic mul;        // form term product
    logic acc;        // accumulate term
    logic div_start;
    logic result;     // form final result into output register
    logic clear;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic log_done;
    logic div_done;
    logic div_first;  // integer quotient pass finished
    logic need_term;  // entry counted, p nonzero, q nonzero
    logic need_div;   // skip mode with nonzero kept sum
    logic is_last;
  } status_t;

endpackage

// File: src/kld_log2.sv
`timescale 1ns / 1ps
// Iterative log2 in Q.24: top-bit index plus 24 squaring steps, one per cycle.
// No package dependencies.
module kld_log2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] x,
  output logic        done,
  output logic [29:0] result
);
  logic [5:0]  e;
  logic [31:0] y;
  logic [23:0] f;
  logic [4:0]  cnt;
  logic        busy;
  logic [5:0]  top;
  logic [63:0] sq;
  logic [32:0] sqs;

  always_comb begin
    top = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (x[i]) top = 6'(i);
    end
  end

  // mantissa stays in [1, 2) as Q1.31, so its square is below 4
  assign sq  = y * y;
  assign sqs = sq[63:31];
  assign result = {e, f};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && cnt == 5'd23;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        f    <= '0;
        e    <= top;
        if (x == 48'd0) begin
          y <= 32'h8000_0000;
        end else if (top >= 6'd31) begin
          y <= 32'(x >> (top - 6'd31));
        end else begin
          y <= 32'(x << (6'd31 - top));
        end
      end else if (busy) begin
        if (sqs[32]) begin
          y <= sqs[32:1];
          f <= {f[22:0], 1'b1};
        end else begin
          y <= sqs[31:0];
          f <= {f[22:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) busy <= 1'b0;
      end
    end
  end
endmodule

// File: src/kld_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: 64-bit dividend over 48-bit divisor.
// Standalone; no package use.
module kld_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [47:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [47:0] rem
);
  logic [48:0] r;
  logic [63:0] qd;
  logic [6:0]  cnt;
  logic        busy;
  logic [48:0] trial;

  assign trial = {r[47:0], qd[63]};
  assign quot = qd;
  assign rem  = r[47:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && cnt == 7'd63;
      if (start) begin
        busy <= 1'b1;
        r    <= '0;
        qd   <= dividend;
        cnt  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          r  <= trial - {1'b0, divisor};
          qd <= {qd[62:0], 1'b1};
        end else begin
          r  <= trial;
          qd <= {qd[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) busy <= 1'b0;
      end
    end
  end
endmodule

// File: src/kld_datapath.sv
`timescale 1ns / 1ps
// Datapath: input capture, log2 and divide units, accumulators, result register.
// Depends on kld_pkg, kld_log2, kld_div.
module kld_datapath (
  input  logic               clk,
  input  logic               rst,
  input  kld_pkg::cmd_t      cmd,
  output kld_pkg::status_t   sts,
  input  logic               skip_zero_q,
  input  logic [31:0]        p_value,
  input  logic [31:0]        q_value,
  input  logic               last,
  output logic [31:0]        divergence_bits,
  output logic               infinite,
  output logic               undefined,
  output logic               saturated
);
  logic [32:0] p, q;
  logic        lst;
  logic [63:0] term_sum;
  logic [47:0] kept_p_sum;
  logic        infinity_seen;
  logic [kld_pkg::CountW-1:0] item_count;
  logic        counted;
  logic [29:0] lp, lq, lres;
  logic        log_done, div_done;
  logic [47:0] log_x;
  logic [29:0] mag;
  logic        pos;
  logic [62:0] prod;
  logic [63:0] tmag;
  logic [63:0] t;
  logic [64:0] sum_ext;
  logic [63:0] m;
  logic [63:0] q0;
  logic [47:0] r0;
  logic        phase2;
  logic [63:0] div_a;
  logic [47:0] div_b;
  logic [40:0] quot_hi;
  logic        over;
  logic [63:0] dq;
  logic [47:0] dr;
  logic [63:0] d;
  logic [48:0] kept_next;
  logic [63:0] dfull;
  logic [63:0] qs;

  assign log_x = cmd.log_sel_s ? kept_p_sum :
                 (cmd.log_sel_q ? {15'd0, q} : {15'd0, p});

  kld_log2 u_log (.clk(clk), .rst(rst), .start(cmd.log_start), .x(log_x),
                  .done(log_done), .result(lres));

  assign m = term_sum[63] ? (64'd0 - term_sum) : term_sum;
  assign div_a = phase2 ? {1'b0, r0, 15'd0} : m;
  assign div_b = kept_p_sum;

  kld_div u_div (.clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_a),
                 .divisor(div_b), .done(div_done), .quot(dq), .rem(dr));

  assign sts.log_done  = log_done;
  assign sts.div_done  = div_done && phase2;
  assign sts.div_first = div_done && !phase2;
  assign sts.need_term = counted && p != 33'd0 && q != 33'd0;
  assign sts.need_div  = skip_zero_q && kept_p_sum != 48'd0;
  assign sts.is_last   = lst;

  assign mag = (lp >= lq) ? lp - lq : lq - lp;
  assign sum_ext = {term_sum[63], term_sum} + {t[63], t};
  assign kept_next = {1'b0, kept_p_sum} + {16'd0, p};

  always_ff @(posedge clk) begin
    if (rst) begin
      term_sum      <= '0;
      kept_p_sum    <= '0;
      infinity_seen <= 1'b0;
      item_count    <= '0;
      phase2        <= 1'b0;
    end else begin
      if (cmd.load) begin
        p   <= (p_value > 32'h8000_0000) ? kld_pkg::OneQ31 : {1'b0, p_value};
        q   <= (q_value > 32'h8000_0000) ? kld_pkg::OneQ31 : {1'b0, q_value};
        lst <= last;
        counted <= item_count < kld_pkg::CountW'(kld_pkg::MaxItems);
        if (item_count < kld_pkg::CountW'(kld_pkg::MaxItems)) begin
          item_count <= item_count + 1'b1;
          if (p_value != 32'd0 && q_value == 32'd0 && !skip_zero_q)
            infinity_seen <= 1'b1;
        end
      end
      if (cmd.save_lp) lp <= lres;
      if (cmd.save_lq) lq <= lres;
      if (cmd.mul) begin
        pos  <= lp >= lq;
        prod <= 63'(mag) * 63'(p);
      end
      if (cmd.acc) begin
        if (sum_ext[64] != sum_ext[63])
          term_sum <= sum_ext[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        else
          term_sum <= sum_ext[63:0];
        if (skip_zero_q)
          kept_p_sum <= kept_next[48] ? kld_pkg::KeptMax : kept_next[47:0];
      end
      // first divide gives the integer quotient, second the 15 fraction bits
      if (div_done && !phase2) begin
        q0 <= dq;
        r0 <= dr;
        phase2 <= 1'b1;
      end
      if (cmd.div_start && !phase2) begin
        // nothing; phase chosen by register
      end
      if (div_done && phase2) quot_hi <= over ? kld_pkg::QuotLimit :
          ((({q0[25:0], 15'd0} + {26'd0, dq[14:0]}) > kld_pkg::QuotLimit) ?
           kld_pkg::QuotLimit : ({q0[25:0], 15'd0} + {26'd0, dq[14:0]}));
      if (cmd.result) begin
        divergence_bits <= d[31:0];
        infinite  <= !skip_zero_q && infinity_seen;
        undefined <= skip_zero_q && kept_p_sum == 48'd0;
        saturated <= !(!skip_zero_q && infinity_seen) &&
                     !(skip_zero_q && kept_p_sum == 48'd0) &&
                     ($signed(dfull) > 64'sd2147483647 ||
                      $signed(dfull) < -64'sd2147483648);
        phase2 <= 1'b0;
      end
      if (cmd.clear) begin
        term_sum      <= '0;
        kept_p_sum    <= '0;
        infinity_seen <= 1'b0;
        item_count    <= '0;
      end
    end
  end

  // an integer quotient of 2^26 or more already clips the scaled quotient
  assign over = q0[63:26] != 38'd0;
  assign tmag = (64'(prod) + 64'h40_0000) >> 23;
  assign t = pos ? tmag : (64'd0 - tmag);

  assign qs = term_sum[63] ? (64'd0 - 64'(quot_hi)) : 64'(quot_hi);
  always_comb begin
    if (!skip_zero_q) begin
      if (infinity_seen) dfull = 64'd2147483647;
      else begin
        dfull = {16'd0, m[63:16]};
        if (term_sum[63]) dfull = 64'd0 - dfull;
      end
    end else if (kept_p_sum == 48'd0) begin
      dfull = 64'd0;
    end else begin
      dfull = qs - 64'(lres[29:8]) + (64'd31 << 16);
    end
    if ($signed(dfull) > 64'sd2147483647) d = 64'd2147483647;
    else if ($signed(dfull) < -64'sd2147483648) d = 64'hFFFF_FFFF_8000_0000;
    else d = dfull;
  end
endmodule

// File: src/kld_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences log2, multiply, accumulate and final divide.
// Depends on kld_pkg.
module kld_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  kld_pkg::status_t   sts,
  output kld_pkg::cmd_t      cmd
);
  kld_pkg::state_t state, state_next;
  logic dphase, dphase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= kld_pkg::ST_IDLE;
      dphase <= 1'b0;
    end else begin
      state  <= state_next;
      dphase <= dphase_next;
    end
  end

  always_comb begin
    state_next  = state;
    dphase_next = dphase;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      kld_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = kld_pkg::ST_LOGP;
        end
      end
      kld_pkg::ST_LOGP: begin
        if (sts.need_term) begin
          cmd.log_start = 1'b1;
          state_next = kld_pkg::ST_LOGQ;
        end else begin
          state_next = kld_pkg::ST_FINAL;
        end
      end
      kld_pkg::ST_LOGQ: begin
        if (sts.log_done) begin
          cmd.save_lp = 1'b1;
          cmd.log_start = 1'b1;
          cmd.log_sel_q = 1'b1;
          state_next = kld_pkg::ST_MUL;
        end
      end
      kld_pkg::ST_MUL: begin
        if (sts.log_done) begin
          cmd.save_lq = 1'b1;
          state_next = kld_pkg::ST_ACC;
        end
      end
      kld_pkg::ST_ACC: begin
        if (!dphase) begin
          cmd.mul = 1'b1;
          dphase_next = 1'b1;
        end else begin
          cmd.acc = 1'b1;
          dphase_next = 1'b0;
          state_next = kld_pkg::ST_FINAL;
        end
      end
      kld_pkg::ST_FINAL: begin
        if (!sts.is_last) state_next = kld_pkg::ST_IDLE;
        else if (sts.need_div) begin
          cmd.div_start = 1'b1;
          dphase_next = 1'b0;
          state_next = kld_pkg::ST_DIV;
        end else state_next = kld_pkg::ST_OUT;
      end
      kld_pkg::ST_DIV: begin
        // kld_divseq launches the remainder pass; on its done, start log2 of the kept sum
        if (!dphase && !sts.div_done && sts.log_done == 1'b0) begin
          state_next = kld_pkg::ST_DIV;
        end
        if (sts.div_done) begin
          cmd.log_start = 1'b1;
          cmd.log_sel_s = 1'b1;
          state_next = kld_pkg::ST_LOGS;
        end
      end
      kld_pkg::ST_LOGS: begin
        cmd.log_sel_s = 1'b1;
        if (sts.log_done) state_next = kld_pkg::ST_OUT;
      end
      kld_pkg::ST_OUT: begin
        cmd.log_sel_s = 1'b1;
        cmd.result = 1'b1;
        cmd.clear = 1'b1;
        state_next = kld_pkg::ST_HOLD;
      end
      kld_pkg::ST_HOLD: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = kld_pkg::ST_IDLE;
      end
      default: state_next = kld_pkg::ST_IDLE;
    endcase
  end
endmodule

// File: src/kld_divseq.sv
`timescale 1ns / 1ps
// Launches the second divide pass in the cycle after the first one finishes,
// once the remainder has been captured. Depends on kld_pkg.
module kld_divseq (
  input  logic          clk,
  input  logic          rst,
  input  kld_pkg::cmd_t cmd_in,
  input  logic          first_done,
  output kld_pkg::cmd_t cmd_out
);
  logic pending;
  logic launch;
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      launch  <= 1'b0;
    end else begin
      launch <= first_done && pending;
      if (cmd_in.div_start) pending <= 1'b1;
      else if (first_done && pending) pending <= 1'b0;
    end
  end
  always_comb begin
    cmd_out = cmd_in;
    if (launch) cmd_out.div_start = 1'b1;
  end
endmodule

// File: src/kl_divergence_accumulator.sv
`timescale 1ns / 1ps
// Channel | direction | handshake
// in      | sink      | in_valid / in_stall : p_value, q_value, last
// out     | source    | out_valid / out_stall : divergence_bits, flags
// cfg     | sink      | cfg_we / cfg_wdata : skip_zero_q
// An entry with a term goes from accept to next accept through two log2
// runs, a multiply and an add; an entry without one skips them.
// The last entry then forms the result, in skip mode with a nonzero kept
// sum after two 64-step divider passes and a 24-step log2 of the kept sum.
// Reset is synchronous and clears mode, accumulators and the controller.
// A result waits in the output register while out_stall is high.
`include "kl_divergence_accumulator_defines.svh"
module kl_divergence_accumulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] p_value,
  input  logic [31:0] q_value,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] divergence_bits,
  output logic        infinite,
  output logic        undefined,
  output logic        saturated
);
  logic skip_zero_q;
  kld_pkg::cmd_t    cmd_c, cmd;
  kld_pkg::status_t sts;

  always_ff @(posedge clk) begin
    if (rst) skip_zero_q <= 1'b0;
    else if (cfg_we) skip_zero_q <= cfg_wdata;
  end

  kld_ctrl u_ctrl (.clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
                   .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd_c));

  kld_divseq u_seq (.clk(clk), .rst(rst), .cmd_in(cmd_c), .first_done(sts.div_first),
                    .cmd_out(cmd));

  kld_datapath u_dp (.clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
                     .skip_zero_q(skip_zero_q), .p_value(p_value), .q_value(q_value),
                     .last(last), .divergence_bits(divergence_bits), .infinite(infinite),
                     .undefined(undefined), .saturated(saturated));

  `KLD_ASSERT_IMP(a_no_accept_busy, clk, rst, out_valid, in_stall,
                  "input accepted while a result is pending")
  `KLD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                   out_valid && $stable(divergence_bits), "stalled result changed")
  `KLD_ASSERT_IMP(a_flags_excl, clk, rst, out_valid, !(infinite && undefined),
                  "infinite and undefined both set")
  `KLD_ASSERT_IMP(a_flag_mode, clk, rst, out_valid && infinite, !saturated,
                  "saturated set on infinite result")
endmodule
